/* rtl/core/c2d_pkg.sv */
package c2d_pkg;

  // Field widths fixed by the item formats
  localparam int CMD_W     = 2;
  localparam int INDEX_W   = 10;
  localparam int VALUE_W   = 16;
  localparam int POS_W     = 3;
  localparam int RES_W     = 40;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 3;

  // Signed coordinate width: covers stride * position + kernel tap - padding
  // and the padded span for every supported map side
  localparam int COORD_W = 8;

  typedef logic [CMD_W-1:0]            cmd_t;
  typedef logic [INDEX_W-1:0]          index_t;
  typedef logic signed [VALUE_W-1:0]   value_t;
  typedef logic [POS_W-1:0]            pos_t;
  typedef logic signed [RES_W-1:0]     result_t;
  typedef logic [CFG_W-1:0]            cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;

  // Command codes
  localparam cmd_t CMD_LOAD_ACT  = 2'd0;
  localparam cmd_t CMD_LOAD_WGT  = 2'd1;
  localparam cmd_t CMD_LOAD_BIAS = 2'd2;
  localparam cmd_t CMD_COMPUTE   = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t REG_IN_CHANNELS  = 3'd0;
  localparam cfg_idx_t REG_OUT_CHANNELS = 3'd1;
  localparam cfg_idx_t REG_INPUT_SIDE   = 3'd2;
  localparam cfg_idx_t REG_KERNEL_SIDE  = 3'd3;
  localparam cfg_idx_t REG_STEP_SIZE    = 3'd4;
  localparam cfg_idx_t REG_PAD_WIDTH    = 3'd5;
  localparam cfg_idx_t REG_RELU_ENABLE  = 3'd6;

endpackage

/* rtl/core/c2d_if.sv */
interface c2d_req_if;
  import c2d_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   cmd;
  index_t store_index;
  value_t load_value;
  pos_t   out_channel;
  pos_t   out_row;
  pos_t   out_col;

  modport source (
    output valid, cmd, store_index, load_value, out_channel, out_row, out_col,
    input  ready
  );

  modport sink (
    input  valid, cmd, store_index, load_value, out_channel, out_row, out_col,
    output ready
  );
endinterface

interface c2d_rsp_if;
  import c2d_pkg::*;

  logic    valid;
  logic    ready;
  result_t conv_result;
  logic    bad_coord;

  modport source (
    output valid, conv_result, bad_coord,
    input  ready
  );

  modport sink (
    input  valid, conv_result, bad_coord,
    output ready
  );
endinterface

/* rtl/core/conv2d_layer_engine.sv */
// Load commands write their store and produce no result.
// A compute command steps through in_channels * kernel_side^2 taps, one tap per cycle
// through the shared multiply-accumulate unit, then drains the pipeline; a bad
// coordinate skips the taps. The next command is taken once the result is registered.
// Synchronous active-high reset clears control, presets configuration; stores not cleared.
module conv2d_layer_engine #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_SIDE     = 8,
  parameter int MAX_KERNEL   = 4,
  parameter int DATA_WIDTH   = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  c2d_pkg::cfg_idx_t   cfg_index,
  input  c2d_pkg::cfg_data_t  cfg_data,
  c2d_req_if.sink             req,
  c2d_rsp_if.source           rsp
);
  import c2d_pkg::*;

  localparam int ACT_DEPTH = MAX_CHANNELS * MAX_SIDE * MAX_SIDE;
  localparam int WGT_DEPTH = MAX_CHANNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
  localparam int WGT_AW    = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int BIAS_AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ICW       = $clog2(MAX_CHANNELS + 1);
  localparam int KCW       = $clog2(MAX_KERNEL + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Configuration registers
  logic [3:0] in_channels;
  logic [3:0] out_channels;
  logic [3:0] input_side;
  logic [2:0] kernel_side;
  logic [2:0] step_size;
  logic [1:0] pad_width;
  logic       relu_enable;

  // Stores
  logic signed [DATA_WIDTH-1:0] act_mem  [ACT_DEPTH];
  logic signed [DATA_WIDTH-1:0] wgt_mem  [WGT_DEPTH];
  logic signed [DATA_WIDTH-1:0] bias_mem [MAX_CHANNELS];

  // Sequencer and datapath registers
  logic [2:0]                     state;
  pos_t                           oc_q;
  pos_t                           orow_q;
  pos_t                           ocol_q;
  logic signed [COORD_W-1:0]      rb;
  logic signed [COORD_W-1:0]      cb;
  logic                           bad_q;
  logic                           first;
  logic [ICW-1:0]                 ic;
  logic [KCW-1:0]                 kr;
  logic [KCW-1:0]                 kc;
  logic                           p1;
  logic                           p2;
  logic signed [DATA_WIDTH-1:0]   act_q;
  logic signed [DATA_WIDTH-1:0]   wgt_q;
  logic signed [DATA_WIDTH-1:0]   bias_q;
  logic signed [2*DATA_WIDTH-1:0] prod;
  result_t                        acc;
  logic                           res_valid;
  result_t                        res_data;
  logic                           res_bad;

  // Combinational helpers
  logic [ICW-1:0]            ich;
  logic [ICW-1:0]            och;
  logic [KCW-1:0]            ks;
  logic [COORD_W-1:0]        side;
  logic [2:0]                st;
  logic [COORD_W-1:0]        span;
  logic [COORD_W-1:0]        row_off;
  logic [COORD_W-1:0]        col_off;
  logic                      bad_now;
  logic                      have_taps;
  logic signed [COORD_W-1:0] r;
  logic signed [COORD_W-1:0] c;
  logic                      inb;
  logic [31:0]               ai_full;
  logic [31:0]               wi_full;
  logic [ACT_AW-1:0]         act_addr;
  logic [WGT_AW-1:0]         wgt_addr;
  logic [BIAS_AW-1:0]        bias_addr;
  logic                      kc_wrap;
  logic                      kr_wrap;
  logic                      last_tap;
  logic                      in_xfer;
  logic                      out_xfer;
  logic                      res_load;
  logic signed [63:0]        prod_wide;
  logic [31:0]               idx_wide;
  logic signed [DATA_WIDTH-1:0] store_val;

  assign in_xfer  = req.valid && req.ready;
  assign out_xfer = rsp.valid && rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign res_load = (state == S_DONE) && (!res_valid || rsp.ready);

  // Saturate configuration to the hardware limits
  always_comb begin
    ich  = (32'(in_channels)  > MAX_CHANNELS) ? ICW'(MAX_CHANNELS) : ICW'(in_channels);
    och  = (32'(out_channels) > MAX_CHANNELS) ? ICW'(MAX_CHANNELS) : ICW'(out_channels);
    ks   = (32'(kernel_side)  > MAX_KERNEL)   ? KCW'(MAX_KERNEL)   : KCW'(kernel_side);
    side = (32'(input_side)   > MAX_SIDE)     ? COORD_W'(MAX_SIDE) : COORD_W'(input_side);
    st   = (step_size == 3'd0) ? 3'd1 : step_size;
    span = side + COORD_W'({pad_width, 1'b0});
    have_taps = (ich != '0) && (ks != '0);
  end

  // Range check: out channel below out_channels, and position p valid when st * p + ks fits the padded span
  always_comb begin
    row_off = COORD_W'(st) * COORD_W'(orow_q);
    col_off = COORD_W'(st) * COORD_W'(ocol_q);
    bad_now = (32'(oc_q) >= 32'(och)) || (span < COORD_W'(ks)) ||
              (row_off + COORD_W'(ks) > span) || (col_off + COORD_W'(ks) > span);
  end

  // Tap address generation
  always_comb begin
    r   = rb + signed'(COORD_W'(kr));
    c   = cb + signed'(COORD_W'(kc));
    inb = have_taps && !r[COORD_W-1] && !c[COORD_W-1] &&
          (r < signed'(side)) && (c < signed'(side));
    ai_full = (32'(ic) * 32'(MAX_SIDE) + 32'(r[COORD_W-2:0])) * 32'(MAX_SIDE) +
              32'(c[COORD_W-2:0]);
    wi_full = ((32'(oc_q) * 32'(MAX_CHANNELS) + 32'(ic)) * 32'(MAX_KERNEL) + 32'(kr)) *
              32'(MAX_KERNEL) + 32'(kc);
    act_addr  = inb ? ai_full[ACT_AW-1:0] : '0;
    wgt_addr  = inb ? wi_full[WGT_AW-1:0] : '0;
    bias_addr = BIAS_AW'(32'(oc_q));
    kc_wrap   = (kc + KCW'(1)) == ks;
    kr_wrap   = (kr + KCW'(1)) == ks;
    last_tap  = !have_taps || (kc_wrap && kr_wrap && ((ic + ICW'(1)) == ich));
  end

  assign idx_wide  = 32'(req.store_index);
  assign store_val = DATA_WIDTH'(req.load_value);
  assign prod_wide = 64'(prod);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_channels  <= 4'd1;
      out_channels <= 4'd1;
      input_side   <= 4'd8;
      kernel_side  <= 3'd1;
      step_size    <= 3'd1;
      pad_width    <= 2'd0;
      relu_enable  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_CHANNELS:  in_channels  <= cfg_data;
        REG_OUT_CHANNELS: out_channels <= cfg_data;
        REG_INPUT_SIDE:   input_side   <= cfg_data;
        REG_KERNEL_SIDE:  kernel_side  <= cfg_data[2:0];
        REG_STEP_SIZE:    step_size    <= cfg_data[2:0];
        REG_PAD_WIDTH:    pad_width    <= cfg_data[1:0];
        REG_RELU_ENABLE:  relu_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Activation store: load port and tap read port
  always_ff @(posedge clk) begin
    if (in_xfer && req.cmd == CMD_LOAD_ACT && idx_wide < 32'(ACT_DEPTH)) begin
      act_mem[idx_wide[ACT_AW-1:0]] <= store_val;
    end
    act_q <= act_mem[act_addr];
  end

  // Weight store
  always_ff @(posedge clk) begin
    if (in_xfer && req.cmd == CMD_LOAD_WGT && idx_wide < 32'(WGT_DEPTH)) begin
      wgt_mem[idx_wide[WGT_AW-1:0]] <= store_val;
    end
    wgt_q <= wgt_mem[wgt_addr];
  end

  // Bias store
  always_ff @(posedge clk) begin
    if (in_xfer && req.cmd == CMD_LOAD_BIAS && idx_wide < 32'(MAX_CHANNELS)) begin
      bias_mem[idx_wide[BIAS_AW-1:0]] <= store_val;
    end
    bias_q <= bias_mem[bias_addr];
  end

  // Shared multiplier and accumulator
  always_ff @(posedge clk) begin
    prod <= act_q * wgt_q;
    if (first) begin
      acc <= RES_W'(bias_q);
    end else if (p2) begin
      acc <= acc + prod_wide[RES_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      first     <= 1'b0;
      p1        <= 1'b0;
      p2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      p1    <= (state == S_RUN) && inb;
      p2    <= p1;
      first <= (state == S_CHECK) && !bad_now;
      // Fill the output register, or release it after its transfer
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_xfer) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer && req.cmd == CMD_COMPUTE) begin
            oc_q   <= req.out_channel;
            orow_q <= req.out_row;
            ocol_q <= req.out_col;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          bad_q <= bad_now;
          rb    <= signed'(row_off - COORD_W'(pad_width));
          cb    <= signed'(col_off - COORD_W'(pad_width));
          ic    <= '0;
          kr    <= '0;
          kc    <= '0;
          if (bad_now) begin
            state <= S_DONE;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          // Advance column, then row, then input channel
          if (last_tap) begin
            state <= S_DRAIN;
          end else if (kc_wrap) begin
            kc <= '0;
            if (kr_wrap) begin
              kr <= '0;
              ic <= ic + ICW'(1);
            end else begin
              kr <= kr + KCW'(1);
            end
          end else begin
            kc <= kc + KCW'(1);
          end
        end
        S_DRAIN: begin
          if (!p1 && !p2) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hold until the output register is free
          if (res_load) begin
            res_bad <= bad_q;
            if (bad_q || (relu_enable && acc[RES_W-1])) begin
              res_data <= '0;
            end else begin
              res_data <= acc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.conv_result = res_data;
  assign rsp.bad_coord   = res_bad;

  // The MAC pipeline is empty whenever a new command can be taken
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !p1 && !p2)
    else $error("tap in flight while idle");

  // A load never starts the sequencer
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    in_xfer && req.cmd != CMD_COMPUTE |=> state == S_IDLE)
    else $error("load left idle state");

  // A flagged coordinate always carries a zero result
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.bad_coord |-> rsp.conv_result == '0)
    else $error("bad coordinate with nonzero result");

  // The bias is loaded only on the first run cycle
  a_first_in_run: assert property (@(posedge clk) disable iff (rst)
    first |-> state == S_RUN && !p2)
    else $error("bias load outside first run cycle");

endmodule
